FILE: rtl/core/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg: shared types and constants of the column ray setup.
// Fixed-point formats, field widths, register indexes and the per-axis result.
// ----------------------------------------------------------------------------
package rcs_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COL_W      = 12;
	localparam int SW_W       = 13;
	localparam int CFG_DIR_W  = 18;
	localparam int POS_W      = 24;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int DIR_W      = 19;
	localparam int CELL_W     = 8;
	localparam int DIST_W     = 32;

	localparam int CAM_NUM_W  = COL_W + 1 + FRAC_BITS;
	localparam int CAM_W      = CAM_NUM_W + 1;
	localparam int PROD_W     = CFG_DIR_W + CAM_W;
	localparam int SUMR_W     = PROD_W - FRAC_BITS + 1;

	localparam int SQ_W       = 2 * DIR_W - 1;
	localparam int SSUM_W     = SQ_W + 1;
	localparam int RAD_W      = SSUM_W + 2 * FRAC_BITS;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int GAP_W      = FRAC_BITS + 1;
	localparam int SIDE_P_W   = GAP_W + DIST_W;

	localparam logic [DIST_W-1:0] DIST_SAT = '1;
	localparam int FRAC_ONE = 1 << FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_X      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POS_X        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y        = 3'd6;

	typedef struct packed {
		logic signed [DIR_W-1:0] ray_dir;
		logic [CELL_W-1:0]       map_cell;
		logic                    step_neg;
		logic [DIST_W-1:0]       delta;
		logic [DIST_W-1:0]       side;
	} rcs_ray_t;

	function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [SUMR_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[SUMR_W-1:DIR_W-1];
		hi_zeros = ~|v[SUMR_W-1:DIR_W-1];
		if (hi_ones || hi_zeros) begin
			return v[DIR_W-1:0];
		end else if (v[SUMR_W-1]) begin
			return {1'b1, {(DIR_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DIR_W-1){1'b1}}};
		end
	endfunction

endpackage

FILE: rtl/core/rcs_div.sv
// ----------------------------------------------------------------------------
// rcs_div: pipelined unsigned restoring divider.
// One quotient bit per stage, a side tag travels along.
// ----------------------------------------------------------------------------
module rcs_div #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 13,
	parameter int TAG_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo,
	output logic [TAG_W-1:0] out_tag
);

	logic             vld_s [1:NUM_W];
	logic [NUM_W-1:0] nq_s  [1:NUM_W];
	logic [DEN_W-1:0] rem_s [1:NUM_W];
	logic [DEN_W-1:0] den_s [1:NUM_W];
	logic [TAG_W-1:0] tag_s [1:NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic             cur_vld;
		logic [NUM_W-1:0] cur_nq;
		logic [DEN_W-1:0] cur_rem;
		logic [DEN_W-1:0] cur_den;
		logic [TAG_W-1:0] cur_tag;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_nq  = num;
			assign cur_rem = '0;
			assign cur_den = den;
			assign cur_tag = in_tag;
		end else begin : g_next
			assign cur_vld = vld_s[k];
			assign cur_nq  = nq_s[k];
			assign cur_rem = rem_s[k];
			assign cur_den = den_s[k];
			assign cur_tag = tag_s[k];
		end

		assign trial = {cur_rem, cur_nq[NUM_W-1]};
		assign ge    = trial >= {1'b0, cur_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			nq_s[k+1]  <= {cur_nq[NUM_W-2:0], ge};
			rem_s[k+1] <= ge ? DEN_W'(trial - {1'b0, cur_den}) : trial[DEN_W-1:0];
			den_s[k+1] <= cur_den;
			tag_s[k+1] <= cur_tag;
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quo       = nq_s[NUM_W];
	assign out_tag   = tag_s[NUM_W];

endmodule

FILE: rtl/core/rcs_sqrt.sv
// ----------------------------------------------------------------------------
// rcs_sqrt: pipelined integer square root.
// Two radicand bits per stage, a side tag travels along.
// ----------------------------------------------------------------------------
module rcs_sqrt #(
	parameter int IN_W  = 70,
	parameter int TAG_W = 65
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [IN_W-1:0]     radicand,
	input  logic [TAG_W-1:0]    in_tag,
	output logic                out_valid,
	output logic [IN_W/2-1:0]   root,
	output logic [TAG_W-1:0]    out_tag
);

	localparam int OUT_W = IN_W / 2;

	logic             vld_s  [1:OUT_W];
	logic [IN_W-1:0]  val_s  [1:OUT_W];
	logic [OUT_W:0]   rem_s  [1:OUT_W];
	logic [OUT_W-1:0] root_s [1:OUT_W];
	logic [TAG_W-1:0] tag_s  [1:OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic             cur_vld;
		logic [IN_W-1:0]  cur_val;
		logic [OUT_W:0]   cur_rem;
		logic [OUT_W-1:0] cur_root;
		logic [TAG_W-1:0] cur_tag;
		logic [OUT_W+2:0] acc;
		logic [OUT_W+2:0] trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign cur_vld  = in_valid;
			assign cur_val  = radicand;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_tag  = in_tag;
		end else begin : g_next
			assign cur_vld  = vld_s[k];
			assign cur_val  = val_s[k];
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_tag  = tag_s[k];
		end

		assign acc   = {cur_rem, cur_val[IN_W-1 -: 2]};
		assign trial = (OUT_W+3)'({cur_root, 2'b01});
		assign ge    = acc >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			val_s[k+1]  <= {cur_val[IN_W-3:0], 2'b00};
			rem_s[k+1]  <= ge ? (OUT_W+1)'(acc - trial) : (OUT_W+1)'(acc);
			root_s[k+1] <= {cur_root[OUT_W-2:0], ge};
			tag_s[k+1]  <= cur_tag;
		end
	end

	assign out_valid = vld_s[OUT_W];
	assign root      = root_s[OUT_W];
	assign out_tag   = tag_s[OUT_W];

endmodule

FILE: rtl/core/rcs_axis.sv
// ----------------------------------------------------------------------------
// rcs_axis: step, cell, delta and side distance for one axis of a ray.
// delta = isqrt((a*a + b*b) << 2F) / |a|, side = gap * delta >> F.
// ----------------------------------------------------------------------------
module rcs_axis import rcs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [DIR_W-1:0] own,
	input  logic signed [DIR_W-1:0] other,
	input  logic [POS_W-1:0]        pos,
	output logic                    out_valid,
	output rcs_ray_t                ray
);

	localparam int STAG_W = 2 * DIR_W + 2 + GAP_W + CELL_W;
	localparam int DTAG_W = DIR_W + 2 + GAP_W + CELL_W;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic [DIR_W-1:0]        abs_own_s1, abs_other_s1, abs_own_s2;
	logic signed [DIR_W-1:0] own_s1, own_s2, own_s3, own_s4;
	logic                    zero_s1, zero_s2, zero_s3, zero_s4;
	logic                    neg_s1, neg_s2, neg_s3, neg_s4;
	logic [GAP_W-1:0]        gap_s1, gap_s2, gap_s3;
	logic [CELL_W-1:0]       cell_s1, cell_s2, cell_s3, cell_s4;
	logic [SQ_W-1:0]         sq_own_s2, sq_other_s2;
	logic [DIST_W-1:0]       delta_s3, delta_s4, side_s4;

	logic [RAD_W-1:0]        radicand;
	logic                    sq_vld;
	logic [ROOT_W-1:0]       sq_root;
	logic [STAG_W-1:0]       sq_tag;
	logic [DIR_W-1:0]        sq_abs_own;
	logic [DTAG_W-1:0]       sq_rest;
	logic                    dv_vld;
	logic [ROOT_W-1:0]       dv_quo;
	logic [DTAG_W-1:0]       dv_tag;
	logic signed [DIR_W-1:0] dv_own;
	logic                    dv_zero, dv_neg;
	logic [GAP_W-1:0]        dv_gap;
	logic [CELL_W-1:0]       dv_cell;
	logic [SIDE_P_W-1:0]     side_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= dv_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		abs_own_s1   <= own[DIR_W-1] ? DIR_W'(-own) : own;
		abs_other_s1 <= other[DIR_W-1] ? DIR_W'(-other) : other;
		own_s1       <= own;
		zero_s1      <= own == '0;
		neg_s1       <= own[DIR_W-1] || own == '0;
		gap_s1       <= (own[DIR_W-1] || own == '0) ? {1'b0, pos[FRAC_BITS-1:0]} :
		                GAP_W'(FRAC_ONE) - {1'b0, pos[FRAC_BITS-1:0]};
		cell_s1      <= pos[FRAC_BITS +: CELL_W];

		sq_own_s2    <= SQ_W'(abs_own_s1) * SQ_W'(abs_own_s1);
		sq_other_s2  <= SQ_W'(abs_other_s1) * SQ_W'(abs_other_s1);
		abs_own_s2   <= abs_own_s1;
		own_s2       <= own_s1;
		zero_s2      <= zero_s1;
		neg_s2       <= neg_s1;
		gap_s2       <= gap_s1;
		cell_s2      <= cell_s1;
	end

	assign radicand = {SSUM_W'(sq_own_s2) + SSUM_W'(sq_other_s2), {(2*FRAC_BITS){1'b0}}};

	rcs_sqrt #(
		.IN_W  (RAD_W),
		.TAG_W (STAG_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.radicand  (radicand),
		.in_tag    ({abs_own_s2, own_s2, zero_s2, neg_s2, gap_s2, cell_s2}),
		.out_valid (sq_vld),
		.root      (sq_root),
		.out_tag   (sq_tag)
	);

	assign {sq_abs_own, sq_rest} = sq_tag;

	rcs_div #(
		.NUM_W (ROOT_W),
		.DEN_W (DIR_W),
		.TAG_W (DTAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_vld),
		.num       (sq_root),
		.den       (sq_abs_own),
		.in_tag    (sq_rest),
		.out_valid (dv_vld),
		.quo       (dv_quo),
		.out_tag   (dv_tag)
	);

	assign {dv_own, dv_zero, dv_neg, dv_gap, dv_cell} = dv_tag;
	assign side_prod = SIDE_P_W'(gap_s3) * SIDE_P_W'(delta_s3);

	always_ff @(posedge clk) begin
		if (dv_zero || dv_quo[ROOT_W-1:DIST_W] != '0) begin
			delta_s3 <= DIST_SAT;
		end else begin
			delta_s3 <= dv_quo[DIST_W-1:0];
		end
		own_s3   <= dv_own;
		zero_s3  <= dv_zero;
		neg_s3   <= dv_neg;
		gap_s3   <= dv_gap;
		cell_s3  <= dv_cell;

		side_s4  <= zero_s3 ? DIST_SAT : side_prod[FRAC_BITS +: DIST_W];
		delta_s4 <= delta_s3;
		own_s4   <= own_s3;
		zero_s4  <= zero_s3;
		neg_s4   <= neg_s3;
		cell_s4  <= cell_s3;
	end

	assign out_valid    = vld_s4;
	assign ray.ray_dir  = own_s4;
	assign ray.map_cell = cell_s4;
	assign ray.step_neg = neg_s4 | zero_s4;
	assign ray.delta    = delta_s4;
	assign ray.side     = side_s4;

endmodule

FILE: rtl/core/raycast_column_ray_setup_core.sv
// ----------------------------------------------------------------------------
// raycast_column_ray_setup_core: per-column DDA ray setup.
// One item is taken every cycle, set by the one-bit-per-stage divider and
// root pipelines, and each accepted item ends in a done strobe.
// busy never rises and results cannot be held off. Reset clears the valid
// chain and loads the configuration defaults; no item is lost or repeated.
// ----------------------------------------------------------------------------
module raycast_column_ray_setup_core import rcs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [COL_W-1:0]         column,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata,
	output logic                     done,
	output logic signed [DIR_W-1:0]  ray_dir_x,
	output logic signed [DIR_W-1:0]  ray_dir_y,
	output logic [CELL_W-1:0]        cell_x,
	output logic [CELL_W-1:0]        cell_y,
	output logic                     step_neg_x,
	output logic                     step_neg_y,
	output logic [DIST_W-1:0]        delta_dist_x,
	output logic [DIST_W-1:0]        delta_dist_y,
	output logic [DIST_W-1:0]        side_dist_x,
	output logic [DIST_W-1:0]        side_dist_y
);

	localparam int LATENCY = 1 + CAM_NUM_W + 3 + 2 + 2 * ROOT_W + 2;

	logic [SW_W-1:0]             screen_width_q;
	logic signed [CFG_DIR_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [POS_W-1:0]            pos_x_q, pos_y_q;

	logic                        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [COL_W-1:0]            column_s1;
	logic signed [CAM_W-1:0]     cam_s2;
	logic [POS_W-1:0]            pos_x_s2, pos_y_s2, pos_x_s3, pos_y_s3, pos_x_s4, pos_y_s4;
	logic signed [PROD_W-1:0]    prod_x_s3, prod_y_s3;
	logic signed [DIR_W-1:0]     rdx_s4, rdy_s4;

	logic [SW_W-1:0]             cam_den;
	logic                        cam_vld;
	logic [CAM_NUM_W-1:0]        cam_q;
	logic [2*POS_W-1:0]          cam_tag;
	logic signed [SUMR_W-1:0]    sum_x, sum_y;
	logic                        ax_vld, ay_vld;
	rcs_ray_t                    ray_x, ray_y;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SW_W'(1024);
			dir_x_q        <= -CFG_DIR_W'(FRAC_ONE);
			dir_y_q        <= '0;
			plane_x_q      <= '0;
			plane_y_q      <= CFG_DIR_W'(52429);
			pos_x_q        <= '0;
			pos_y_q        <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_wdata[SW_W-1:0];
				REG_DIR_X:        dir_x_q        <= cfg_wdata[CFG_DIR_W-1:0];
				REG_DIR_Y:        dir_y_q        <= cfg_wdata[CFG_DIR_W-1:0];
				REG_PLANE_X:      plane_x_q      <= cfg_wdata[CFG_DIR_W-1:0];
				REG_PLANE_Y:      plane_y_q      <= cfg_wdata[CFG_DIR_W-1:0];
				REG_POS_X:        pos_x_q        <= cfg_wdata[POS_W-1:0];
				REG_POS_Y:        pos_y_q        <= cfg_wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= cam_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign cam_den = (screen_width_q == '0) ? SW_W'(1) : screen_width_q;

	always_ff @(posedge clk) begin
		column_s1 <= column;
	end

	rcs_div #(
		.NUM_W (CAM_NUM_W),
		.DEN_W (SW_W),
		.TAG_W (2 * POS_W)
	) u_cam_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.num       ({column_s1, 1'b0, {FRAC_BITS{1'b0}}}),
		.den       (cam_den),
		.in_tag    ({pos_x_q, pos_y_q}),
		.out_valid (cam_vld),
		.quo       (cam_q),
		.out_tag   (cam_tag)
	);

	always_comb begin
		sum_x = SUMR_W'(dir_x_q) + SUMR_W'($signed(prod_x_s3[PROD_W-1:FRAC_BITS]));
		sum_y = SUMR_W'(dir_y_q) + SUMR_W'($signed(prod_y_s3[PROD_W-1:FRAC_BITS]));
	end

	always_ff @(posedge clk) begin
		cam_s2    <= {1'b0, cam_q} - CAM_W'(FRAC_ONE);
		pos_x_s2  <= cam_tag[2*POS_W-1:POS_W];
		pos_y_s2  <= cam_tag[POS_W-1:0];

		prod_x_s3 <= PROD_W'(plane_x_q) * PROD_W'(cam_s2);
		prod_y_s3 <= PROD_W'(plane_y_q) * PROD_W'(cam_s2);
		pos_x_s3  <= pos_x_s2;
		pos_y_s3  <= pos_y_s2;

		rdx_s4    <= sat_dir(sum_x);
		rdy_s4    <= sat_dir(sum_y);
		pos_x_s4  <= pos_x_s3;
		pos_y_s4  <= pos_y_s3;
	end

	rcs_axis u_axis_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.own       (rdx_s4),
		.other     (rdy_s4),
		.pos       (pos_x_s4),
		.out_valid (ax_vld),
		.ray       (ray_x)
	);

	rcs_axis u_axis_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.own       (rdy_s4),
		.other     (rdx_s4),
		.pos       (pos_y_s4),
		.out_valid (ay_vld),
		.ray       (ray_y)
	);

	assign done         = ax_vld & ay_vld;
	assign ray_dir_x    = ray_x.ray_dir;
	assign ray_dir_y    = ray_y.ray_dir;
	assign cell_x       = ray_x.map_cell;
	assign cell_y       = ray_y.map_cell;
	assign step_neg_x   = ray_x.step_neg;
	assign step_neg_y   = ray_y.step_neg;
	assign delta_dist_x = ray_x.delta;
	assign delta_dist_y = ray_y.delta;
	assign side_dist_x  = ray_x.side;
	assign side_dist_y  = ray_y.side;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item did not complete after the pipeline latency");

	a_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ray_dir_x == '0) |->
		(delta_dist_x == DIST_SAT && side_dist_x == DIST_SAT && step_neg_x))
		else $error("zero x direction not saturated");

	a_zero_y: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ray_dir_y == '0) |->
		(delta_dist_y == DIST_SAT && side_dist_y == DIST_SAT && step_neg_y))
		else $error("zero y direction not saturated");

	a_step_x: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (step_neg_x == (ray_dir_x[DIR_W-1] || ray_dir_x == '0)))
		else $error("x step sign does not match the ray direction");

endmodule

FILE: test/ray_setup_checker.sv
// ----------------------------------------------------------------------------
// ray_setup_checker: scoreboard for the column ray setup core.
// Mirrors the configuration writes and, for every accepted column, works out
// the expected ray direction, start cell, step signs and grid distances.
// Each done strobe is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module ray_setup_checker import rcs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [COL_W-1:0]        column,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    done,
	input  logic signed [DIR_W-1:0] ray_dir_x,
	input  logic signed [DIR_W-1:0] ray_dir_y,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic                    step_neg_x,
	input  logic                    step_neg_y,
	input  logic [DIST_W-1:0]       delta_dist_x,
	input  logic [DIST_W-1:0]       delta_dist_y,
	input  logic [DIST_W-1:0]       side_dist_x,
	input  logic [DIST_W-1:0]       side_dist_y,
	output int                      pending,
	output int                      fail_count,
	output int                      rays_checked
);

	typedef struct {
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic [CELL_W-1:0]       cx;
		logic [CELL_W-1:0]       cy;
		logic                    nx;
		logic                    ny;
		logic [DIST_W-1:0]       dx;
		logic [DIST_W-1:0]       dy;
		logic [DIST_W-1:0]       sx;
		logic [DIST_W-1:0]       sy;
	} ray_t;

	ray_t rays_due[$];

	logic [SW_W-1:0]             m_width;
	logic signed [CFG_DIR_W-1:0] m_dir_x, m_dir_y, m_plane_x, m_plane_y;
	logic [POS_W-1:0]            m_pos_x, m_pos_y;

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'h1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint steer(logic signed [CFG_DIR_W-1:0] d,
			logic signed [CFG_DIR_W-1:0] p, longint cam);
		longint r;
		r = longint'(d) + ((longint'(p) * cam) >>> FRAC_BITS);
		if (r < -262144) r = -262144;
		if (r > 262143) r = 262143;
		return r;
	endfunction

	function automatic logic [DIST_W-1:0] grid_step(longint own, longint other);
		logic [63:0]  a, b, q, root;
		logic [127:0] quo;
		a = own < 0 ? -own : own;
		b = other < 0 ? -other : other;
		if (a == 0) return DIST_SAT;
		quo = ({64'h0, a * a + b * b} << (2 * FRAC_BITS)) / {64'h0, a * a};
		q = quo > 128'hFFFF_FFFF_FFFF_FFFF ? '1 : quo[63:0];
		root = int_sqrt(q);
		return root > 64'hFFFF_FFFF ? DIST_SAT : root[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] first_line(longint own, logic [POS_W-1:0] pos,
			logic [DIST_W-1:0] delta);
		logic [63:0] line_gap, prod;
		if (own == 0) return DIST_SAT;
		line_gap = own <= 0 ? 64'(pos[FRAC_BITS-1:0]) : 64'(FRAC_ONE) - pos[FRAC_BITS-1:0];
		prod = (line_gap * delta) >> FRAC_BITS;
		return prod[DIST_W-1:0];
	endfunction

	function automatic ray_t set_up_ray(logic [COL_W-1:0] col);
		ray_t   e;
		longint w, cam, rx, ry;
		w = m_width == 0 ? 1 : m_width;
		cam = ((longint'(col) * 2) << FRAC_BITS) / w - FRAC_ONE;
		rx = steer(m_dir_x, m_plane_x, cam);
		ry = steer(m_dir_y, m_plane_y, cam);
		e.dir_x = rx[DIR_W-1:0];
		e.dir_y = ry[DIR_W-1:0];
		e.cx = m_pos_x[POS_W-1:FRAC_BITS];
		e.cy = m_pos_y[POS_W-1:FRAC_BITS];
		e.nx = rx <= 0;
		e.ny = ry <= 0;
		e.dx = grid_step(rx, ry);
		e.dy = grid_step(ry, rx);
		e.sx = first_line(rx, m_pos_x, e.dx);
		e.sy = first_line(ry, m_pos_y, e.dy);
		return e;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("ray %0d: %s is %0h, expected %0h", rays_checked, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		rays_checked = 0;
	end

	assign pending = rays_due.size();

	always @(posedge clk or negedge arst_n) begin
		ray_t e;
		if (!arst_n) begin
			m_width   <= SW_W'(1024);
			m_dir_x   <= CFG_DIR_W'(-65536);
			m_dir_y   <= '0;
			m_plane_x <= '0;
			m_plane_y <= CFG_DIR_W'(52429);
			m_pos_x   <= '0;
			m_pos_y   <= '0;
		end else begin
			if (start && !busy) rays_due.push_back(set_up_ray(column));
			if (done) begin
				if (rays_due.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					e = rays_due.pop_front();
					if (ray_dir_x != e.dir_x) report("ray_dir_x", ray_dir_x, e.dir_x);
					if (ray_dir_y != e.dir_y) report("ray_dir_y", ray_dir_y, e.dir_y);
					if (cell_x != e.cx) report("cell_x", cell_x, e.cx);
					if (cell_y != e.cy) report("cell_y", cell_y, e.cy);
					if (step_neg_x != e.nx) report("step_neg_x", step_neg_x, e.nx);
					if (step_neg_y != e.ny) report("step_neg_y", step_neg_y, e.ny);
					if (delta_dist_x != e.dx) report("delta_dist_x", delta_dist_x, e.dx);
					if (delta_dist_y != e.dy) report("delta_dist_y", delta_dist_y, e.dy);
					if (side_dist_x != e.sx) report("side_dist_x", side_dist_x, e.sx);
					if (side_dist_y != e.sy) report("side_dist_y", side_dist_y, e.sy);
				end
				rays_checked++;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SCREEN_WIDTH: m_width   <= cfg_wdata[SW_W-1:0];
					REG_DIR_X:        m_dir_x   <= cfg_wdata[CFG_DIR_W-1:0];
					REG_DIR_Y:        m_dir_y   <= cfg_wdata[CFG_DIR_W-1:0];
					REG_PLANE_X:      m_plane_x <= cfg_wdata[CFG_DIR_W-1:0];
					REG_PLANE_Y:      m_plane_y <= cfg_wdata[CFG_DIR_W-1:0];
					REG_POS_X:        m_pos_x   <= cfg_wdata[POS_W-1:0];
					REG_POS_Y:        m_pos_y   <= cfg_wdata[POS_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the column ray setup core.
// Drives directed columns under hand-picked camera settings, then random
// columns under many random and extreme settings with varying sender gaps.
// A separate checker predicts and compares every ray.
// ----------------------------------------------------------------------------
module testbench;
	import rcs_pkg::*;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    start = 0;
	logic                    busy;
	logic [COL_W-1:0]        column = '0;
	logic                    cfg_wr_en = 0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_W-1:0]        cfg_wdata = '0;
	logic                    done;
	logic signed [DIR_W-1:0] ray_dir_x, ray_dir_y;
	logic [CELL_W-1:0]       cell_x, cell_y;
	logic                    step_neg_x, step_neg_y;
	logic [DIST_W-1:0]       delta_dist_x, delta_dist_y, side_dist_x, side_dist_y;
	int                      pending, fail_count, rays_checked;
	int                      quiet_cycles = 0;
	int                      columns_sent = 0;
	int                      settings_used = 0;
	int                      cur_width = 1024;
	logic [COL_W-1:0]        first_cols [7];

	always #5 clk = ~clk;

	raycast_column_ray_setup_core dut (.*);

	ray_setup_checker checker_i (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000) begin
			$display("raycast_column_ray_setup_core: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_camera(int w, int dx, int dy, int px, int py, int sx, int sy);
		write_reg(REG_SCREEN_WIDTH, CFG_W'(w));
		write_reg(REG_DIR_X, CFG_W'(dx & 'h3FFFF));
		write_reg(REG_DIR_Y, CFG_W'(dy & 'h3FFFF));
		write_reg(REG_PLANE_X, CFG_W'(px & 'h3FFFF));
		write_reg(REG_PLANE_Y, CFG_W'(py & 'h3FFFF));
		write_reg(REG_POS_X, CFG_W'(sx));
		write_reg(REG_POS_Y, CFG_W'(sy));
		cfg_wr_en <= 0;
		@(posedge clk);
		cur_width = w;
		settings_used++;
	endtask

	task automatic send_column(logic [COL_W-1:0] col, int gap_pct);
		logic taken;
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		column <= col;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		columns_sent++;
	endtask

	task automatic drain;
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic int pick_dir();
		case ($urandom_range(5))
			0: return -131072;
			1: return 131071;
			2: return 0;
			default: return int'($urandom_range(0, 'h3FFFF)) - 131072;
		endcase
	endfunction

	function automatic int pick_pos();
		case ($urandom_range(4))
			0: return 0;
			1: return 'hFFFFFF;
			2: return $urandom_range(0, 255) << 16;
			default: return $urandom_range(0, 'hFFFFFF);
		endcase
	endfunction

	function automatic int pick_width();
		case ($urandom_range(7))
			0: return 1;
			1: return 4096;
			2: return 0;
			3: return 8191;
			4: return $urandom_range(1, 32);
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	initial begin
		int gap;
		int lim;
		first_cols = '{12'd0, 12'd1, 12'd512, 12'd1023, 12'd1024, 12'd2047, 12'd4095};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < 7; i++) send_column(first_cols[i], 0);
		drain;
		set_camera(0, 131071, -131072, 131071, 131071, 'hFFFFFF, 'hFFFFFF);
		send_column(12'd0, 0);
		send_column(12'd4095, 0);
		send_column(12'd1, 0);
		send_column(12'd2048, 0);
		drain;
		set_camera(4096, 0, 0, 0, 0, 'h123456, 'hABCDEF);
		send_column(12'd0, 0);
		send_column(12'd2048, 0);
		send_column(12'd4095, 0);
		drain;
		set_camera(256, 0, 65536, 0, 43690, 'h050000, 'h0A0000);
		send_column(12'd0, 0);
		send_column(12'd100, 0);
		send_column(12'd255, 0);
		drain;

		for (int ph = 0; ph < 12; ph++) begin
			gap = ph < 4 ? 13 : (ph < 8 ? 51 : 0);
			set_camera(pick_width(), pick_dir(), pick_dir(), pick_dir(), pick_dir(),
				pick_pos(), pick_pos());
			lim = cur_width == 0 ? 1 : (cur_width > 4096 ? 4096 : cur_width);
			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(7) == 0) send_column(COL_W'($urandom_range(0, 4095)), gap);
				else send_column(COL_W'($urandom_range(0, lim - 1)), gap);
			end
			drain;
		end

		repeat (120) @(posedge clk);
		$display("Sent %0d columns under %0d camera settings; %0d rays checked.",
			columns_sent, settings_used + 1, rays_checked);
		if (fail_count == 0 && pending == 0) begin
			$display("raycast_column_ray_setup_core: match");
		end else begin
			$display("raycast_column_ray_setup_core: mismatch");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/rcs_pkg.sv
rtl/core/rcs_div.sv
rtl/core/rcs_sqrt.sv
rtl/core/rcs_axis.sv
rtl/core/raycast_column_ray_setup_core.sv
test/ray_setup_checker.sv
test/testbench.sv
